// ===== rtl/cassette_tape_frame_encoder_defines.svh =====
// Assertion macros shared by the cassette tape frame encoder modules.
`ifndef CASSETTE_TAPE_FRAME_ENCODER_DEFINES_SVH
`define CASSETTE_TAPE_FRAME_ENCODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CTF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ctf assertion failed");

// Next-cycle implication, checked outside reset.
`define CTF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ctf assertion failed");

`endif

// ===== rtl/ctf_pkg.sv =====
// Shared types and constants of the cassette tape frame encoder.
package ctf_pkg;

    typedef enum logic [2:0] {
        OP_DATA    = 3'd0,
        OP_HEADER  = 3'd1,
        OP_PROGRAM = 3'd2,
        OP_PARITY  = 3'd3,
        OP_LEADER  = 3'd4,
        OP_SILENCE = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        JOB_FRAME   = 2'd0,
        JOB_LEADER  = 2'd1,
        JOB_SILENCE = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [7:0]  frame_byte;
        logic [14:0] samples;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    localparam logic [7:0]  KEY_HDR_MC    = 8'h26;
    localparam logic [7:0]  KEY_HDR_BASIC = 8'h16;
    localparam logic [7:0]  KEY_PRG_MC    = 8'h27;
    localparam logic [7:0]  KEY_PRG_BASIC = 8'h17;

    localparam logic [15:0] PAT_ONE  = 16'hF0F0;
    localparam logic [15:0] PAT_ZERO = 16'hFF00;

    // ms*192/10 = (ms*96)/5; divide by 5 as multiply by ceil(2^20/5), exact below 2^18
    localparam int          RECIP_SHIFT = 20;
    localparam logic [17:0] RECIP_FIVE  = 18'd209716;

    localparam int          CELLS_PER_FRAME   = 11;
    localparam logic [3:0]  LAST_CELL         = 4'(CELLS_PER_FRAME - 1);
    localparam int          QUEUE_DEPTH_DEF   = 2;

endpackage

// ===== rtl/ctf_front.sv =====
// Front end: accepts opcodes, keeps the checksum and mode, builds queue jobs.
module ctf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_opcode,
    input  logic [7:0]         i_data_byte,
    input  logic [9:0]         i_silence_ms,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data,
    input  ctf_pkg::t_q_status i_q_status,
    output logic               o_push,
    output ctf_pkg::t_job      o_job
);
    import ctf_pkg::*;

    logic        r_mode;
    logic [7:0]  r_sum;
    logic [7:0]  n_sum;
    logic        accept;
    logic        push_req;
    logic [16:0] ms_x96;
    logic [34:0] div_prod;
    t_job        job;

    assign o_in_stall  = i_q_status.full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !i_q_status.full;

    assign ms_x96   = {1'b0, i_silence_ms, 6'b0} + {2'b0, i_silence_ms, 5'b0};
    assign div_prod = {18'b0, ms_x96} * {17'b0, RECIP_FIVE};

    always_comb begin
        job      = '{kind: JOB_FRAME, frame_byte: 8'h00, samples: 15'd0};
        n_sum    = r_sum;
        push_req = 1'b1;
        unique case (i_opcode)
            OP_DATA: begin
                job.frame_byte = i_data_byte;
                n_sum          = r_sum + i_data_byte;
            end
            OP_HEADER: begin
                job.frame_byte = r_mode ? KEY_HDR_MC : KEY_HDR_BASIC;
                n_sum          = 8'h00;
            end
            OP_PROGRAM: begin
                job.frame_byte = r_mode ? KEY_PRG_MC : KEY_PRG_BASIC;
                n_sum          = 8'h00;
            end
            OP_PARITY: begin
                // negated checksum plus checksum wraps to zero
                job.frame_byte = 8'h00 - r_sum;
                n_sum          = 8'h00;
            end
            OP_LEADER: begin
                job.kind = JOB_LEADER;
            end
            OP_SILENCE: begin
                job.kind    = JOB_SILENCE;
                job.samples = div_prod[RECIP_SHIFT +: 15];
            end
            default: begin
                push_req = 1'b0;
            end
        endcase
    end

    assign o_push = accept && push_req;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
            r_sum  <= 8'h00;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (accept) begin
                r_sum <= n_sum;
            end
        end
    end

endmodule

// ===== rtl/ctf_queue.sv =====
// Short job queue between front end and cell serializer.
`include "cassette_tape_frame_encoder_defines.svh"

module ctf_queue #(
    parameter int DEPTH = ctf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ctf_pkg::t_job      i_job,
    input  logic               i_pop,
    output ctf_pkg::t_job      o_head,
    output ctf_pkg::t_q_status o_status
);
    import ctf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_slots [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_slots[r_rd_ptr];
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `CTF_ASSERT_IMPL(a_no_push_full, i_push, !o_status.full)
    `CTF_ASSERT_IMPL(a_no_pop_empty, i_pop, !o_status.empty)
    `CTF_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH))

endmodule

// ===== rtl/ctf_back.sv =====
// Back end: serializes queued jobs into bit cells and silence runs.
`include "cassette_tape_frame_encoder_defines.svh"

module ctf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ctf_pkg::t_job      i_head,
    input  ctf_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_cell_kind,
    output logic [15:0]        o_cell_pattern,
    output logic [14:0]        o_silence_samples,
    output logic               o_last_of_run
);
    import ctf_pkg::*;

    logic [3:0]  r_cell;
    logic        r_out_valid;
    logic        r_kind;
    logic [15:0] r_pattern;
    logic [14:0] r_samples;
    logic        r_last;
    logic        load;
    logic        emit;
    logic        cell_last;
    logic        cell_bit;
    logic [2:0]  bit_idx;

    assign load    = !r_out_valid || !i_out_stall;
    assign emit    = load && !i_q_status.empty;
    assign bit_idx = 3'(r_cell - 4'd1);

    always_comb begin
        cell_last = 1'b1;
        cell_bit  = 1'b1;
        if (i_head.kind == JOB_FRAME) begin
            cell_last = (r_cell == LAST_CELL);
            if (r_cell == 4'd0) begin
                cell_bit = 1'b0;
            end else if (r_cell <= 4'd8) begin
                cell_bit = i_head.frame_byte[bit_idx];
            end
        end
    end

    assign o_pop = emit && cell_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell      <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= !i_q_status.empty;
            end
            if (emit) begin
                r_cell <= cell_last ? 4'd0 : r_cell + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_last <= cell_last;
            if (i_head.kind == JOB_SILENCE) begin
                r_kind    <= 1'b1;
                r_pattern <= 16'h0000;
                r_samples <= i_head.samples;
            end else begin
                r_kind    <= 1'b0;
                r_pattern <= cell_bit ? PAT_ONE : PAT_ZERO;
                r_samples <= 15'd0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_cell_kind       = r_kind;
    assign o_cell_pattern    = r_pattern;
    assign o_silence_samples = r_samples;
    assign o_last_of_run     = r_last;

    `CTF_ASSERT_IMPL(a_cell_bound, 1'b1, r_cell <= LAST_CELL)
    `CTF_ASSERT_IMPL(a_silence_last, r_out_valid && r_kind, r_last)
    `CTF_ASSERT_NEXT(a_pop_restarts, o_pop, r_cell == 4'd0)

endmodule

// ===== rtl/cassette_tape_frame_encoder.sv =====
// Top level of the cassette tape frame encoder.
// Turns a stream of tape opcodes into Kansas City style bit cells of 16 samples
// (a one is 0xF0F0, two short cycles; a zero is 0xFF00, one long cycle, bit 15
// played first) and mid-level silence runs. Data, header key, program key and
// parity opcodes each give eleven cells: start 0, eight data bits LSB first,
// two stop 1s, the last flagged by o_last_of_run. Key opcodes send 0x26/0x27
// (machine code mode, the reset value) or 0x16/0x17 and clear the checksum;
// parity sends the negated checksum. Leader gives one 1 cell, silence gives one
// run of ms*192/10 samples. Opcodes six and seven are taken and dropped.
// Rate: the cell serializer emits one cell per cycle while the output is not
// stalled and a job is queued. The front end takes the next opcode in the cycle
// after the last one while a queue of QUEUE_DEPTH jobs has room, so the
// serializer runs without gaps; an accepted job is registered in a queue slot
// and then in the output register. Write the mode register only while idle.
module cassette_tape_frame_encoder #(
    parameter int QUEUE_DEPTH = ctf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_data_byte,
    input  logic [9:0]  i_silence_ms,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_cell_kind,
    output logic [15:0] o_cell_pattern,
    output logic [14:0] o_silence_samples,
    output logic        o_last_of_run,
    // mode register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);
    import ctf_pkg::*;

    logic      push;
    logic      pop;
    t_job      push_job;
    t_job      head_job;
    t_q_status q_status;

    // classify opcodes, hold checksum and mode
    ctf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_data_byte (i_data_byte),
        .i_silence_ms(i_silence_ms),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_job       (push_job)
    );

    // decouple the two sides
    ctf_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_status(q_status)
    );

    // advance one cell per free output slot while a job is queued
    ctf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head_job),
        .i_q_status       (q_status),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_cell_kind      (o_cell_kind),
        .o_cell_pattern   (o_cell_pattern),
        .o_silence_samples(o_silence_samples),
        .o_last_of_run    (o_last_of_run)
    );

endmodule
